FILE: rtl/core/ps2kr_pkg.sv
// Shared types and constants for the PS/2 keyboard receiver.
// No dependencies; used by ps2kr_frame, ps2_keyboard_receiver and ps2kr_checker.
`timescale 1ns / 1ps

package ps2kr_pkg;

    localparam int CNT_W = 16;

    // Configuration register indexes.
    localparam logic [2:0] REG_CLOCK_BIT   = 3'd0;
    localparam logic [2:0] REG_RELEASE     = 3'd1;
    localparam logic [2:0] REG_EXTEND      = 3'd2;
    localparam logic [2:0] REG_SHIFT       = 3'd3;
    localparam logic [2:0] REG_CTRL        = 3'd4;
    localparam logic [2:0] REG_ALT         = 3'd5;

    // Reset values of the configuration registers.
    localparam logic [2:0] RST_CLOCK_BIT   = 3'd0;
    localparam logic [7:0] RST_RELEASE     = 8'hF0;
    localparam logic [7:0] RST_EXTEND      = 8'hE0;
    localparam logic [7:0] RST_SHIFT       = 8'h12;
    localparam logic [7:0] RST_CTRL        = 8'h14;
    localparam logic [7:0] RST_ALT         = 8'h11;

    // Item kinds on the input side.
    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_POLL   = 1'b1;

    // Key event codes on the output side.
    localparam logic [1:0] KEY_NONE    = 2'd0;
    localparam logic [1:0] KEY_PRESS   = 2'd1;
    localparam logic [1:0] KEY_RELEASE = 2'd2;

    // Modifier bits.
    localparam logic [2:0] MOD_SHIFT = 3'b001;
    localparam logic [2:0] MOD_CTRL  = 3'b010;
    localparam logic [2:0] MOD_ALT   = 3'b100;

    // Bit position of byte_pending in the result tdata.
    localparam int PENDING_POS = 59;

    // What the frame receiver tells the top level.
    typedef struct packed {
        logic             pending;       // a byte waits now
        logic [7:0]       rx_byte;       // the waiting byte
        logic             n_pending;     // pending after this cycle
        logic [CNT_W-1:0] n_parity_cnt;
        logic [CNT_W-1:0] n_stop_cnt;
        logic [CNT_W-1:0] n_overrun_cnt;
    } t_frame_status;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        sat_inc = (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
    endfunction

endpackage

FILE: rtl/core/ps2_keyboard_receiver.sv
// Top level of the PS/2 keyboard receiver: edge detection, key decoding, result buffer.
// Depends on ps2kr_pkg and ps2kr_frame.
`timescale 1ns / 1ps

// The block takes one item per clock while s_axis_tready is high. Each result
// is registered, in the output or the skid register, for the master side. A
// sample item (tuser low) carries the whole clock port in tdata[7:0] and the
// PS/2 data level in tdata[8]; on a rising edge of the configured clock bit the
// data level is shifted into the frame receiver (start bit, eight data bits LSB
// first, odd parity, stop bit). A poll item (tuser high) takes the received
// byte, if any, and decodes the release prefix, the extend prefix and the
// shift, ctrl and alt modifier keys. Every item produces exactly one result:
// the key event in tuser and, in tdata, the held modifiers, the polled key
// code, the three saturating error counters and the byte pending flag. A
// two-entry output buffer (output register plus skid register) lets the block
// keep taking items while a result waits; s_axis_tready drops only when both
// entries hold results. Configuration registers are written through the cfg
// port, which is always ready, and should be written only while the block is
// idle. Only the low PORT_WIDTH bits of the clock port are watched.

module ps2_keyboard_receiver #(
    parameter int PORT_WIDTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] clock_port, [8] data_line, rest zero
    input  logic        s_axis_tuser,   // [0] action

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [2:0] modifier_flags, [10:3] key_code,
                                        // [26:11] parity_errors, [42:27] stop_errors,
                                        // [58:43] overrun_errors, [59] byte_pending,
                                        // rest zero
    output logic [1:0]  m_axis_tuser,   // [1:0] key_event

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    // Mask of the clock port bits that exist at this port width.
    localparam logic [7:0] PORT_MASK =
        (PORT_WIDTH >= 8) ? 8'hFF : 8'((32'd1 << PORT_WIDTH) - 32'd1);

    // Configuration registers.
    logic [2:0] r_clock_bit;
    logic [7:0] r_release_code;
    logic [7:0] r_extend_code;
    logic [7:0] r_shift_code;
    logic [7:0] r_ctrl_code;
    logic [7:0] r_alt_code;

    // Decoder state.
    logic [7:0] r_last_port, n_last_port;
    logic       r_released, n_released;
    logic [2:0] r_mods, n_mods;

    // Output buffer.
    logic        r_out_valid;
    logic [63:0] r_out_data;
    logic [1:0]  r_out_user;
    logic        r_skid_valid;
    logic [63:0] r_skid_data;
    logic [1:0]  r_skid_user;

    logic        in_xfer;
    logic        out_free;
    logic        is_poll;
    logic [7:0]  port_now;
    logic [7:0]  rise;
    logic        clk_bit_ok;
    logic        bit_en;
    logic        take;
    logic [1:0]  res_event;
    logic [7:0]  res_key;
    logic [2:0]  mod_hit;
    logic [63:0] res_data;

    ps2kr_pkg::t_frame_status frame_st;

    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !r_skid_valid;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // Configuration writes; indexes past the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_bit    <= ps2kr_pkg::RST_CLOCK_BIT;
            r_release_code <= ps2kr_pkg::RST_RELEASE;
            r_extend_code  <= ps2kr_pkg::RST_EXTEND;
            r_shift_code   <= ps2kr_pkg::RST_SHIFT;
            r_ctrl_code    <= ps2kr_pkg::RST_CTRL;
            r_alt_code     <= ps2kr_pkg::RST_ALT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ps2kr_pkg::REG_CLOCK_BIT: r_clock_bit    <= i_cfg_data[2:0];
                ps2kr_pkg::REG_RELEASE:   r_release_code <= i_cfg_data;
                ps2kr_pkg::REG_EXTEND:    r_extend_code  <= i_cfg_data;
                ps2kr_pkg::REG_SHIFT:     r_shift_code   <= i_cfg_data;
                ps2kr_pkg::REG_CTRL:      r_ctrl_code    <= i_cfg_data;
                ps2kr_pkg::REG_ALT:       r_alt_code     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Edge detection on the selected clock bit. A clock bit beyond the port
    // width never shows an edge.
    assign is_poll    = (s_axis_tuser == ps2kr_pkg::ACT_POLL);
    assign port_now   = s_axis_tdata[7:0] & PORT_MASK;
    assign rise       = ~r_last_port & port_now;
    assign clk_bit_ok = (32'(r_clock_bit) < PORT_WIDTH);
    assign bit_en     = in_xfer && !is_poll && clk_bit_ok && rise[r_clock_bit];
    assign take       = in_xfer && is_poll;

    ps2kr_frame u_frame (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_bit_en (bit_en),
        .i_bit    (s_axis_tdata[8]),
        .i_take   (take),
        .o_status (frame_st)
    );

    // Poll decoding. Prefixes and modifier keys give no event; the first
    // matching code in the order release, extend, shift, ctrl, alt wins.
    always_comb begin
        n_last_port = r_last_port;
        n_released  = r_released;
        n_mods      = r_mods;
        res_event   = ps2kr_pkg::KEY_NONE;
        res_key     = 8'd0;
        mod_hit     = 3'b000;
        if (in_xfer && !is_poll) begin
            n_last_port = port_now;
        end
        if (take && frame_st.pending) begin
            res_key = frame_st.rx_byte;
            if (res_key == r_release_code) begin
                n_released = 1'b1;
            end else if (res_key == r_extend_code) begin
                n_released = r_released;
            end else begin
                if (res_key == r_shift_code) begin
                    mod_hit = ps2kr_pkg::MOD_SHIFT;
                end else if (res_key == r_ctrl_code) begin
                    mod_hit = ps2kr_pkg::MOD_CTRL;
                end else if (res_key == r_alt_code) begin
                    mod_hit = ps2kr_pkg::MOD_ALT;
                end else begin
                    res_event = r_released ? ps2kr_pkg::KEY_RELEASE
                                           : ps2kr_pkg::KEY_PRESS;
                end
                if (mod_hit != 3'b000) begin
                    n_mods = r_released ? (r_mods & ~mod_hit) : (r_mods | mod_hit);
                end
                n_released = 1'b0;
            end
        end
    end

    assign res_data = {4'd0,
                       frame_st.n_pending,
                       frame_st.n_overrun_cnt,
                       frame_st.n_stop_cnt,
                       frame_st.n_parity_cnt,
                       res_key,
                       n_mods};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_port <= 8'h01 & PORT_MASK;
            r_released  <= 1'b0;
            r_mods      <= 3'b000;
        end else begin
            r_last_port <= n_last_port;
            r_released  <= n_released;
            r_mods      <= n_mods;
        end
    end

    // Output buffer control. When the output register is free it takes the
    // skid entry first, else the new result; otherwise a new result parks in
    // the skid register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= in_xfer;
            end
        end else if (in_xfer) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out_data <= r_skid_data;
                r_out_user <= r_skid_user;
            end else if (in_xfer) begin
                r_out_data <= res_data;
                r_out_user <= res_event;
            end
        end else if (in_xfer) begin
            r_skid_data <= res_data;
            r_skid_user <= res_event;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule

FILE: rtl/core/ps2kr_frame.sv
// PS/2 frame receiver: start, eight data bits, odd parity, stop; error counters.
// Depends on ps2kr_pkg.
`timescale 1ns / 1ps

module ps2kr_frame (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_bit_en,   // a clock rising edge was sampled
    input  logic                    i_bit,      // data line level at that edge
    input  logic                    i_take,     // a poll takes the pending byte
    output ps2kr_pkg::t_frame_status o_status
);

    typedef enum logic [1:0] {
        PH_START,
        PH_DATA,
        PH_PARITY,
        PH_STOP
    } t_phase;

    t_phase                     r_phase, n_phase;
    logic [2:0]                 r_cnt, n_cnt;
    logic [7:0]                 r_shift, n_shift;
    logic [7:0]                 r_byte;
    logic                       r_pending, n_pending;
    logic [ps2kr_pkg::CNT_W-1:0] r_par, n_par;
    logic [ps2kr_pkg::CNT_W-1:0] r_stp, n_stp;
    logic [ps2kr_pkg::CNT_W-1:0] r_ovr, n_ovr;
    logic                       good_stop;

    always_comb begin
        n_phase   = r_phase;
        n_cnt     = r_cnt;
        n_shift   = r_shift;
        n_par     = r_par;
        n_stp     = r_stp;
        n_ovr     = r_ovr;
        good_stop = 1'b0;
        if (i_bit_en) begin
            unique case (r_phase)
                PH_START: begin
                    if (!i_bit) begin
                        n_phase = PH_DATA;
                        n_cnt   = 3'd0;
                    end
                end
                PH_DATA: begin
                    n_shift = {i_bit, r_shift[7:1]};
                    n_cnt   = r_cnt + 3'd1;
                    if (r_cnt == 3'd7) begin
                        n_phase = PH_PARITY;
                    end
                end
                PH_PARITY: begin
                    // Odd parity over data and parity bit.
                    if (^{i_bit, r_shift}) begin
                        n_phase = PH_STOP;
                    end else begin
                        n_par   = ps2kr_pkg::sat_inc(r_par);
                        n_phase = PH_START;
                    end
                end
                PH_STOP: begin
                    if (i_bit) begin
                        good_stop = 1'b1;
                        if (r_pending) begin
                            n_ovr = ps2kr_pkg::sat_inc(r_ovr);
                        end
                    end else begin
                        n_stp = ps2kr_pkg::sat_inc(r_stp);
                    end
                    n_phase = PH_START;
                end
                default: n_phase = PH_START;
            endcase
        end
        if (i_take) begin
            n_pending = 1'b0;
        end else if (good_stop) begin
            n_pending = 1'b1;
        end else begin
            n_pending = r_pending;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_START;
            r_cnt     <= 3'd0;
            r_shift   <= 8'd0;
            r_pending <= 1'b0;
            r_par     <= '0;
            r_stp     <= '0;
            r_ovr     <= '0;
        end else begin
            r_phase   <= n_phase;
            r_cnt     <= n_cnt;
            r_shift   <= n_shift;
            r_pending <= n_pending;
            r_par     <= n_par;
            r_stp     <= n_stp;
            r_ovr     <= n_ovr;
        end
    end

    // The received byte needs no reset; it is read only while pending.
    always_ff @(posedge i_clk) begin
        if (good_stop) begin
            r_byte <= r_shift;
        end
    end

    assign o_status.pending       = r_pending;
    assign o_status.rx_byte       = r_byte;
    assign o_status.n_pending     = n_pending;
    assign o_status.n_parity_cnt  = n_par;
    assign o_status.n_stop_cnt    = n_stp;
    assign o_status.n_overrun_cnt = n_ovr;

endmodule

FILE: rtl/core/ps2kr_checker.sv
// Port-level checks for the PS/2 keyboard receiver, bound to the top level.
// Depends on ps2kr_pkg and ps2_keyboard_receiver.
`timescale 1ns / 1ps

module ps2kr_port_checks (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // No result is shown in the first cycle after reset is released.
    a_idle_after_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !m_axis_tvalid)
        else $error("result valid right after reset");

    // The key event never takes the unused code.
    a_event_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == ps2kr_pkg::KEY_NONE ||
                           m_axis_tuser == ps2kr_pkg::KEY_PRESS ||
                           m_axis_tuser == ps2kr_pkg::KEY_RELEASE))
        else $error("bad key event code");

    // A key event comes from a poll that consumed the byte, so nothing waits.
    a_event_clears_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != ps2kr_pkg::KEY_NONE)
            |-> !m_axis_tdata[ps2kr_pkg::PENDING_POS])
        else $error("byte still pending after a key event");

    // A stalled result holds.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready)
            |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind ps2_keyboard_receiver ps2kr_port_checks u_port_checks (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
